>>> hw/rtl/cigar_interval_overlap_counter_defines.svh
// Assertion macros for the file that checks its own logic.
`ifndef CIGAR_INTERVAL_OVERLAP_COUNTER_DEFINES_SVH
`define CIGAR_INTERVAL_OVERLAP_COUNTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CIOC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CIOC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/cioc_pkg.sv
package cioc_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_OP    = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  localparam logic [2:0] OP_S = 3'd0;
  localparam logic [2:0] OP_M = 3'd1;
  localparam logic [2:0] OP_N = 3'd2;
  localparam logic [2:0] OP_I = 3'd3;
  localparam logic [2:0] OP_D = 3'd4;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_BAD_READ  = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;
  localparam logic [1:0] STAT_BAD_INDEX = 2'd3;

  localparam logic [32:0] POS_LIMIT = 33'h07FFFFFFF;

  // What an alignment operation does to the read.
  typedef enum logic [1:0] {
    OPC_MATCH   = 2'd0,
    OPC_ADVANCE = 2'd1,
    OPC_STAY    = 2'd2,
    OPC_BAD     = 2'd3
  } op_class_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  chrom_id;
    logic [30:0] position;
    logic [30:0] end_position;
    logic [2:0]  op_code;
    logic [27:0] op_length;
    logic        last_op;
    logic [7:0]  entry_index;
  } req_t;

  typedef struct packed {
    logic [31:0] count_value;
    logic [1:0]  status;
    logic [8:0]  table_size;
  } rsp_t;

  // Classified request handed from the front to the back.
  typedef struct packed {
    cmd_t        cmd;
    op_class_t   opc;
    logic [7:0]  chrom_id;
    logic [30:0] position;
    logic [30:0] end_position;
    logic [27:0] op_length;
    logic        last_op;
    logic [7:0]  entry_index;
  } job_t;

  typedef struct packed {
    logic [7:0]  chrom;
    logic [30:0] start;
    logic [30:0] stop;
  } interval_t;

  function automatic op_class_t classify_op(logic [2:0] op);
    op_class_t c;
    case (op)
      OP_M:       c = OPC_MATCH;
      OP_N, OP_D: c = OPC_ADVANCE;
      OP_S, OP_I: c = OPC_STAY;
      default:    c = OPC_BAD;
    endcase
    return c;
  endfunction

endpackage

>>> hw/rtl/cioc_ram.sv
module cioc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/cioc_front.sv
module cioc_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  cioc_pkg::req_t req,
  output logic          job_valid,
  output cioc_pkg::job_t job,
  input  logic          job_take
);
  import cioc_pkg::*;

  localparam int QDEPTH = 2;

  job_t       q [QDEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  job_t       job_in;
  logic       do_push;

  always_comb begin
    job_in.cmd          = cmd_t'(req.command);
    job_in.opc          = classify_op(req.op_code);
    job_in.chrom_id     = req.chrom_id;
    job_in.position     = req.position;
    job_in.end_position = req.end_position;
    job_in.op_length    = req.op_length;
    job_in.last_op      = req.last_op;
    job_in.entry_index  = req.entry_index;
  end

  assign full      = (cnt == 2'(QDEPTH));
  assign job_valid = (cnt != 2'd0);
  assign job       = q[rd_ptr];
  assign do_push   = push && !full;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (job_take) begin
        rd_ptr <= !rd_ptr;
      end
      cnt <= cnt + 2'(do_push) - 2'(job_take);
    end
  end

endmodule

>>> hw/rtl/cioc_back.sv
module cioc_back #(
  parameter int MAX_INTERVALS = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  input  cioc_pkg::job_t job,
  output logic           job_take,
  output logic           rsp_valid,
  output cioc_pkg::rsp_t rsp,
  input  logic           pop
);
  import cioc_pkg::*;

  localparam int AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int CW = $clog2(MAX_INTERVALS + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_COUNT = 4'b0100,
    S_FETCH = 4'b1000
  } state_t;

  state_t             state, state_next;
  logic [CW-1:0]      loaded;
  logic [7:0]         read_chrom;
  logic [31:0]        cursor;
  logic               read_bad;
  logic [MAX_INTERVALS-1:0] hit;
  logic               pend_last;
  logic [31:0]        seg_lo;
  logic [31:0]        seg_sum;
  logic [CW-1:0]      sweep;
  logic               pipe_v;
  logic [AW-1:0]      pipe_idx;

  interval_t          iv_wdata, iv_rdata;
  logic               iv_we;
  logic [31:0]        cnt_rdata, cnt_wdata;
  logic               cnt_we;
  logic [AW-1:0]      cnt_waddr, cnt_raddr;

  logic [32:0]        adv_sum;
  logic               bad_next;
  logic               can_load;
  logic               idx_ok;
  logic               sweep_issue;
  logic               sweep_done;
  logic               seg_hit;
  logic               res_set;
  rsp_t               res_data;
  logic               hits_clear;

  assign job_take    = (state == S_IDLE) && job_valid && !rsp_valid;
  assign adv_sum     = {1'b0, cursor} + 33'(job.op_length);
  assign can_load    = loaded < CW'(MAX_INTERVALS);
  assign idx_ok      = 32'(job.entry_index) < 32'(loaded);
  assign sweep_issue = sweep < loaded;
  assign sweep_done  = !sweep_issue && !pipe_v;

  always_comb begin
    case (job.opc)
      OPC_MATCH, OPC_ADVANCE: bad_next = read_bad || (adv_sum > POS_LIMIT);
      OPC_BAD:                bad_next = 1'b1;
      default:                bad_next = read_bad;
    endcase
  end

  // A segment whose end wrapped below zero covers everything from its start.
  assign seg_hit = pipe_v && (iv_rdata.chrom == read_chrom)
                   && ({1'b0, iv_rdata.stop} >= seg_lo)
                   && ((seg_sum == 32'd0) || (seg_sum > {1'b0, iv_rdata.start}));

  assign iv_we    = job_take && (job.cmd == CMD_LOAD) && can_load;
  assign iv_wdata = '{chrom: job.chrom_id, start: job.position, stop: job.end_position};

  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = loaded[AW-1:0];
    cnt_wdata = '0;
    if (iv_we) begin
      cnt_we = 1'b1;
    end else if (state == S_COUNT && pipe_v && hit[pipe_idx] && cnt_rdata != '1) begin
      cnt_we    = 1'b1;
      cnt_waddr = pipe_idx;
      cnt_wdata = cnt_rdata + 32'd1;
    end
    cnt_raddr = (state == S_IDLE) ? AW'(job.entry_index) : sweep[AW-1:0];
  end

  cioc_ram #(.WIDTH($bits(interval_t)), .DEPTH(MAX_INTERVALS)) u_iv_ram (
    .clk   (clk),
    .we    (iv_we),
    .waddr (loaded[AW-1:0]),
    .wdata (iv_wdata),
    .raddr (sweep[AW-1:0]),
    .rdata (iv_rdata)
  );

  cioc_ram #(.WIDTH(32), .DEPTH(MAX_INTERVALS)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  always_comb begin
    state_next = state;
    res_set    = 1'b0;
    hits_clear = 1'b0;
    res_data   = '{count_value: 32'd0, status: STAT_OK, table_size: 9'(loaded)};
    case (state)
      S_IDLE: begin
        if (job_take) begin
          case (job.cmd)
            CMD_LOAD: begin
              res_set = 1'b1;
              if (can_load) begin
                res_data.table_size = 9'(loaded + CW'(1));
              end else begin
                res_data.status = STAT_FULL;
              end
            end
            CMD_START: begin
              res_set    = 1'b1;
              hits_clear = 1'b1;
            end
            CMD_OP: begin
              if (job.opc == OPC_MATCH && !read_bad && loaded != '0) begin
                state_next = S_SCAN;
              end else if (job.last_op && !bad_next && loaded != '0) begin
                state_next = S_COUNT;
              end else begin
                res_set         = 1'b1;
                hits_clear      = job.last_op;
                res_data.status = bad_next ? STAT_BAD_READ : STAT_OK;
              end
            end
            default: begin
              if (idx_ok) begin
                state_next = S_FETCH;
              end else begin
                res_set         = 1'b1;
                res_data.status = STAT_BAD_INDEX;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        if (sweep_done) begin
          if (pend_last && !read_bad) begin
            state_next = S_COUNT;
          end else begin
            state_next      = S_IDLE;
            res_set         = 1'b1;
            hits_clear      = pend_last;
            res_data.status = read_bad ? STAT_BAD_READ : STAT_OK;
          end
        end
      end
      S_COUNT: begin
        if (sweep_done) begin
          state_next = S_IDLE;
          res_set    = 1'b1;
          hits_clear = 1'b1;
        end
      end
      S_FETCH: begin
        state_next           = S_IDLE;
        res_set              = 1'b1;
        res_data.count_value = cnt_rdata;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      loaded     <= '0;
      read_chrom <= 8'd0;
      cursor     <= 32'd0;
      read_bad   <= 1'b0;
      hit        <= '0;
      pipe_v     <= 1'b0;
      sweep      <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (iv_we) begin
        loaded              <= loaded + CW'(1);
        hit[loaded[AW-1:0]] <= 1'b0;
      end
      if (job_take && job.cmd == CMD_START) begin
        read_chrom <= job.chrom_id;
        cursor     <= {1'b0, job.position};
        read_bad   <= 1'b0;
      end
      if (job_take && job.cmd == CMD_OP) begin
        read_bad <= bad_next;
        if (job.opc == OPC_MATCH || job.opc == OPC_ADVANCE) begin
          cursor <= adv_sum[32] ? 32'hFFFF_FFFF : adv_sum[31:0];
        end
      end
      if (state == S_SCAN && seg_hit) begin
        hit[pipe_idx] <= 1'b1;
      end
      if (hits_clear) begin
        hit <= '0;
      end
      // Sweep pointer: one entry read per cycle, its result seen in the next cycle.
      if (state_next != state) begin
        sweep  <= '0;
        pipe_v <= 1'b0;
      end else begin
        pipe_v <= sweep_issue;
        if (sweep_issue) begin
          sweep <= sweep + CW'(1);
        end
      end
      if (res_set) begin
        rsp_valid <= 1'b1;
      end else if (pop && rsp_valid) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pipe_idx <= sweep[AW-1:0];
    if (job_take) begin
      pend_last <= job.last_op;
      seg_lo    <= cursor;
      seg_sum   <= adv_sum[31:0];
    end
    if (res_set) begin
      rsp <= res_data;
    end
  end

endmodule

>>> hw/rtl/cigar_interval_overlap_counter.sv
// Interval overlap counter for aligned reads.
// Requests enter through a queue-style port: a request is taken on a clock
// edge where push is high and full is low. Each request yields exactly one
// result, shown on rsp while empty is low and taken on an edge where pop is
// high and empty is low. Results come out in request order.
// A front stage classifies each request into a two-entry queue, so the port
// keeps taking requests while the back end is busy or a result waits.
// A load, a read start or a non-match operation that needs no count sweep
// has its result on the port in the cycle after it is taken; a count read
// first reads the count memory in a fetch state. A match operation on a
// good read with a non-empty table sweeps the interval table once, one
// entry per cycle. The last operation of such a read adds a sweep over the
// count memory. Each sweep goes through the single read port of a table
// memory; the back end takes no new request during a sweep or while a result waits.
// Reset clears the table size, the read state and the hit flags; interval
// contents are only read after being loaded, so the memories are not swept.
// When the receiver stalls, the finished result holds, the back end waits,
// and the front queue fills and then raises full.
`include "cigar_interval_overlap_counter_defines.svh"

module cigar_interval_overlap_counter #(
  parameter int MAX_INTERVALS = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  cioc_pkg::req_t req,
  output logic           empty,
  input  logic           pop,
  output cioc_pkg::rsp_t rsp
);
  import cioc_pkg::*;

  logic job_valid;
  job_t job;
  logic job_take;
  logic rsp_valid;

  // Front end: queue and decode of incoming requests.
  cioc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .req       (req),
    .job_valid (job_valid),
    .job       (job),
    .job_take  (job_take)
  );

  // Back end: table memories, read state, sweeps and the result register.
  cioc_back #(.MAX_INTERVALS(MAX_INTERVALS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job),
    .job_take  (job_take),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .pop       (pop)
  );

  assign empty = !rsp_valid;

  // The reported table size never passes the table capacity.
  `CIOC_ASSERT_NOW(a_size_cap, !empty, 32'(rsp.table_size) <= 32'(MAX_INTERVALS), "size over cap")
  // A table-full status only appears once the table is at capacity.
  `CIOC_ASSERT_NOW(a_full_cap, !empty && rsp.status == STAT_FULL, 32'(rsp.table_size) == 32'(MAX_INTERVALS), "full early")
  // A bad index always reports a zero count.
  `CIOC_ASSERT_NOW(a_bad_zero, !empty && rsp.status == STAT_BAD_INDEX, rsp.count_value == 32'd0, "bad index count")
  // The back end only takes a request when it has one to take.
  `CIOC_ASSERT_NOW(a_take_valid, job_take, job_valid, "take without request")

endmodule

>>> dv/tb_cigar_interval_overlap_counter.sv
`default_nettype none

module tb_cigar_interval_overlap_counter;
  timeunit 1ns;
  timeprecision 1ps;

  import cioc_pkg::*;

  // Clock and reset.
  logic clk = 1'b0;
  logic rst = 1'b1;
  always #6 clk = ~clk;

  // DUT ports. Every input starts at a known value.
  logic push = 1'b0;
  logic full;
  req_t req = '0;
  logic empty;
  logic pop = 1'b0;
  rsp_t rsp;

  cigar_interval_overlap_counter u_dut (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .req   (req),
    .empty (empty),
    .pop   (pop),
    .rsp   (rsp)
  );

  localparam int TABLE_DEPTH = 256;

  // Requests waiting to be offered, and results we still expect to see.
  req_t pending_reqs[$];
  rsp_t expected_rsps[$];

  int unsigned reqs_accepted = 0;
  int unsigned rsps_checked = 0;
  int unsigned mismatches = 0;
  int unsigned n_loads = 0;
  int unsigned n_starts = 0;
  int unsigned n_ops = 0;
  int unsigned n_count_reads = 0;
  int unsigned n_counts_bumped = 0;
  int unsigned n_bad_status = 0;

  // Receiver hold-off used to back the block up until full rises.
  logic hold_pop = 1'b0;

  // Our own copy of the interval table and the read tracking state.
  logic [7:0]  itv_chrom [TABLE_DEPTH];
  logic [30:0] itv_start [TABLE_DEPTH];
  logic [30:0] itv_end   [TABLE_DEPTH];
  logic [31:0] itv_count [TABLE_DEPTH];
  logic        itv_hit   [TABLE_DEPTH];
  logic [8:0]  itv_total = '0;
  logic [7:0]  cur_chrom = '0;
  logic [31:0] cur_cursor = '0;
  logic        cur_bad = 1'b0;

  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      itv_hit[i] = 1'b0;
      itv_count[i] = '0;
    end
  end

  // Queue appends.
  function automatic void append_req(req_t r);
    pending_reqs.insert(pending_reqs.size(), r);
  endfunction

  function automatic void append_rsp(rsp_t o);
    expected_rsps.insert(expected_rsps.size(), o);
  endfunction

  // Move the reference cursor; past the 31-bit range the read turns bad, and
  // past the 32-bit range the cursor pins at all ones.
  function automatic void move_cursor(logic [27:0] len);
    logic [32:0] nxt;
    nxt = {1'b0, cur_cursor} + {5'b0, len};
    if (nxt > POS_LIMIT) cur_bad = 1'b1;
    if (nxt[32]) nxt = 33'h0FFFFFFFF;
    cur_cursor = nxt[31:0];
  endfunction

  // Apply one accepted request to the tracked state and return the result
  // the block has to produce for it.
  function automatic rsp_t overlap_outcome(req_t r);
    rsp_t o;
    logic [63:0] seg_lo;
    logic [63:0] seg_hi;
    o = '0;
    case (cmd_t'(r.command))
      CMD_LOAD: begin
        n_loads++;
        if (itv_total >= TABLE_DEPTH) begin
          o.status = STAT_FULL;
        end else begin
          itv_chrom[itv_total[7:0]] = r.chrom_id;
          itv_start[itv_total[7:0]] = r.position;
          itv_end[itv_total[7:0]] = r.end_position;
          itv_count[itv_total[7:0]] = '0;
          itv_hit[itv_total[7:0]] = 1'b0;
          itv_total++;
        end
      end
      CMD_START: begin
        n_starts++;
        cur_chrom = r.chrom_id;
        cur_cursor = {1'b0, r.position};
        cur_bad = 1'b0;
        for (int i = 0; i < TABLE_DEPTH; i++) itv_hit[i] = 1'b0;
      end
      CMD_OP: begin
        n_ops++;
        if (r.op_code == OP_M) begin
          // A zero-length match puts its end one below the cursor; only at cursor
          // zero does the 64-bit end wrap around and act as a huge end.
          seg_lo = {32'b0, cur_cursor};
          seg_hi = seg_lo + {36'b0, r.op_length} - 64'd1;
          if (!cur_bad) begin
            for (int i = 0; i < itv_total; i++) begin
              if (itv_chrom[i] == cur_chrom && seg_lo <= {33'b0, itv_end[i]} &&
                  seg_hi >= {33'b0, itv_start[i]})
                itv_hit[i] = 1'b1;
            end
          end
          move_cursor(r.op_length);
        end else if (r.op_code == OP_N || r.op_code == OP_D) begin
          move_cursor(r.op_length);
        end else if (r.op_code != OP_S && r.op_code != OP_I) begin
          cur_bad = 1'b1;
        end
        if (r.last_op) begin
          for (int i = 0; i < itv_total; i++) begin
            if (itv_hit[i] && !cur_bad && itv_count[i] != 32'hFFFFFFFF) begin
              itv_count[i]++;
              n_counts_bumped++;
            end
          end
          for (int i = 0; i < TABLE_DEPTH; i++) itv_hit[i] = 1'b0;
        end
        o.status = cur_bad ? STAT_BAD_READ : STAT_OK;
        if (cur_bad) n_bad_status++;
      end
      default: begin
        n_count_reads++;
        if (r.entry_index < itv_total) o.count_value = itv_count[r.entry_index];
        else o.status = STAT_BAD_INDEX;
      end
    endcase
    o.table_size = itv_total;
    return o;
  endfunction

  // Idle draws: some stretches run with no gaps at all.
  function automatic int unsigned idle_draw();
    if ((reqs_accepted / 150) % 3 == 0) return 0;
    return $urandom_range(0, 4);
  endfunction

  // Driver: offers requests from the pending queue, holding a request while
  // full is high, with a random gap after each one.
  int unsigned send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (!(push && full)) begin
      if (push) begin
        append_rsp(overlap_outcome(req));
        reqs_accepted++;
      end
      if (send_gap > 0) begin
        push <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_reqs.size() > 0) begin
        req <= pending_reqs.pop_front();
        push <= 1'b1;
        send_gap <= idle_draw();
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Monitor: checks each taken result against the oldest expectation and
  // stalls pop at random.
  int unsigned pop_gap = 0;
  always @(posedge clk) begin
    rsp_t exp_rsp;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        rsps_checked++;
        if (expected_rsps.size() == 0) begin
          $error("result with no request outstanding: %p", rsp);
          mismatches++;
        end else begin
          exp_rsp = expected_rsps.pop_front();
          if (rsp.count_value !== exp_rsp.count_value) begin
            $error("count_value expected %0d actual %0d", exp_rsp.count_value,
                   rsp.count_value);
            mismatches++;
          end
          if (rsp.status !== exp_rsp.status) begin
            $error("status expected %0d actual %0d", exp_rsp.status, rsp.status);
            mismatches++;
          end
          if (rsp.table_size !== exp_rsp.table_size) begin
            $error("table_size expected %0d actual %0d", exp_rsp.table_size,
                   rsp.table_size);
            mismatches++;
          end
        end
      end
      if (hold_pop) begin
        pop <= 1'b0;
      end else if (pop_gap > 0) begin
        pop <= 1'b0;
        pop_gap <= pop_gap - 1;
      end else begin
        pop <= 1'b1;
        if (pop && !empty) pop_gap <= idle_draw();
      end
    end
  end

  // Long receiver stall, timed in its own process, while the driver keeps
  // offering so the front queue fills and full asserts.
  initial begin
    wait (reqs_accepted >= 200);
    @(posedge clk);
    hold_pop <= 1'b1;
    repeat (300) @(posedge clk);
    hold_pop <= 1'b0;
  end

  // Request builders. Fields a command ignores carry random bits.
  int unsigned gen_loaded = 0;

  function automatic req_t noise_req();
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    return raw[$bits(req_t)-1:0];
  endfunction

  function automatic void add_load(logic [7:0] chrom, logic [30:0] lo, logic [30:0] hi);
    req_t r;
    r = noise_req();
    r.command = CMD_LOAD;
    r.chrom_id = chrom;
    r.position = lo;
    r.end_position = hi;
    append_req(r);
    if (gen_loaded < TABLE_DEPTH) gen_loaded++;
  endfunction

  function automatic void add_start(logic [7:0] chrom, logic [30:0] pos);
    req_t r;
    r = noise_req();
    r.command = CMD_START;
    r.chrom_id = chrom;
    r.position = pos;
    append_req(r);
  endfunction

  function automatic void add_op(logic [2:0] op, logic [27:0] len, logic last);
    req_t r;
    r = noise_req();
    r.command = CMD_OP;
    r.op_code = op;
    r.op_length = len;
    r.last_op = last;
    append_req(r);
  endfunction

  function automatic void add_count_read(logic [7:0] idx);
    req_t r;
    r = noise_req();
    r.command = CMD_READ;
    r.entry_index = idx;
    append_req(r);
  endfunction

  // Chromosomes are mostly drawn from a small set so reads often land on intervals.
  function automatic logic [7:0] pick_chrom();
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k < 4) return k[7:0];
    if (k < 6) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void add_random_interval();
    logic [30:0] lo;
    int unsigned k;
    k = $urandom_range(0, 19);
    lo = 31'($urandom_range(1, 2000));
    if (k == 0) add_load(pick_chrom(), 31'($urandom), 31'($urandom));
    else if (k == 1) add_load(pick_chrom(), lo, lo - 31'($urandom_range(1, 50)));
    else add_load(pick_chrom(), lo, lo + 31'($urandom_range(0, 300)));
  endfunction

  // A well-formed read with random content, sometimes spoiled by a bad code,
  // a huge length, or extra operations after the last one.
  function automatic void add_random_read();
    int unsigned n_op;
    int unsigned k;
    logic [2:0] op;
    logic [27:0] len;
    add_start(pick_chrom(), ($urandom_range(0, 15) == 0) ? 31'($urandom)
                                                         : 31'($urandom_range(1, 2500)));
    n_op = $urandom_range(1, 6);
    for (int j = 0; j < n_op; j++) begin
      k = $urandom_range(0, 39);
      if (k < 16) op = OP_M;
      else if (k < 22) op = OP_N;
      else if (k < 27) op = OP_D;
      else if (k < 32) op = OP_S;
      else if (k < 37) op = OP_I;
      else op = 3'($urandom_range(5, 7));
      len = ($urandom_range(0, 24) == 0) ? 28'($urandom) : 28'($urandom_range(0, 200));
      add_op(op, len, j == n_op - 1);
    end
    if ($urandom_range(0, 9) == 0)
      add_op(OP_M, 28'($urandom_range(0, 100)), 1'($urandom_range(0, 1)));
  endfunction

  // Stimulus: directed cases first, then a long random run on a small table,
  // then the table filled to the top with a short run at full size.
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty-table bad index, loads, a counted read, zero-length
    // match, every operation code, cursor overflow, and operations after
    // the last one of a read.
    add_count_read(8'd0);
    add_load(8'd0, 31'd100, 31'd199);
    add_load(8'd0, 31'd200, 31'd200);
    add_load(8'd255, 31'h7FFFFFFF, 31'h7FFFFFFF);
    add_load(8'd0, 31'd0, 31'h7FFFFFFF);
    add_start(8'd0, 31'd150);
    add_op(OP_S, 28'd5, 1'b0);
    add_op(OP_M, 28'd10, 1'b0);
    add_op(OP_I, 28'd3, 1'b0);
    add_op(OP_N, 28'd40, 1'b0);
    add_op(OP_M, 28'd0, 1'b0);
    add_op(OP_D, 28'd1, 1'b1);
    add_op(OP_M, 28'd1, 1'b1);
    add_count_read(8'd0);
    add_count_read(8'd1);
    add_count_read(8'd4);
    add_count_read(8'd255);
    add_start(8'd255, 31'h7FFFFFFF);
    add_op(OP_M, 28'd1, 1'b1);
    add_start(8'd0, 31'h7FFFFFF0);
    add_op(OP_M, 28'hFFFFFFF, 1'b0);
    add_op(3'd5, 28'd0, 1'b1);
    add_start(8'd0, 31'd1);
    add_op(3'd6, 28'd7, 1'b0);
    add_op(3'd7, 28'd7, 1'b1);
    add_count_read(8'd2);

    // Random, small table.
    while (pending_reqs.size() < 1250) begin
      int unsigned k;
      k = $urandom_range(0, 29);
      if (gen_loaded < 24 && k < 3) add_random_interval();
      else if (k < 20) add_random_read();
      else if (k < 27) add_count_read(gen_loaded > 0 && k < 26 ?
                                      8'($urandom_range(0, gen_loaded - 1)) :
                                      8'($urandom));
      else append_req(noise_req());
    end

    // Fill the table, overflow it, and run a few reads at full size.
    while (gen_loaded < TABLE_DEPTH) add_random_interval();
    add_load(8'd1, 31'd5, 31'd6);
    add_count_read(8'd255);
    for (int j = 0; j < 40; j++) begin
      if (j % 3 == 0) add_count_read(8'($urandom));
      else add_random_read();
    end

    wait (pending_reqs.size() == 0);
    @(posedge clk);
    while (push || expected_rsps.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);

    $display("Checked %0d results for %0d requests: %0d loads, %0d read starts, %0d ops,",
             rsps_checked, reqs_accepted, n_loads, n_starts, n_ops);
    $display("%0d count reads, %0d count increments, %0d ops on bad reads.",
             n_count_reads, n_counts_bumped, n_bad_status);
    if (mismatches == 0 && expected_rsps.size() == 0 && rsps_checked == reqs_accepted) begin
      $display("tb_cigar_interval_overlap_counter: PASS");
    end else begin
      $display("tb_cigar_interval_overlap_counter: FAIL");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #30_000_000;
    $display("tb_cigar_interval_overlap_counter: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
